@@ sv/sorted_integer_set_table_top_macros.svh @@
// ----------------------------------------------------------------------------
// sorted integer set table assertion macros
// concurrent check wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SORTED_INTEGER_SET_TABLE_TOP_MACROS_SVH
`define SORTED_INTEGER_SET_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SIST_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("sist same-cycle check failed");

// next-cycle implication
`define SIST_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("sist next-cycle check failed");

`else

`define SIST_ASSERT_IMP(label, clk, rst, pre, post)
`define SIST_ASSERT_NXT(label, clk, rst, pre, post)

`endif

`endif

@@ sv/sist_pkg.sv @@
// ----------------------------------------------------------------------------
// sist_pkg
// types, codes and sizes shared by the sorted integer set table
// ----------------------------------------------------------------------------
package sist_pkg;

   localparam int CAPACITY      = 16;
   localparam int VALUE_W       = 32;
   localparam int POS_W         = 4;
   localparam int STATUS_W      = 3;
   localparam int ENTRY_COUNT_W = 5;
   localparam int IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W         = $clog2(CAPACITY + 1);
   localparam int CMP_W         = (CNT_W > POS_W) ? CNT_W : POS_W;

   // request codes
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_READ      = 3'd5;

   typedef struct packed {
      logic [1:0]                req_type;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } sist_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic                      position_valid;
      logic signed [VALUE_W-1:0] entry_value;
      logic [ENTRY_COUNT_W-1:0]  entry_count;
   } sist_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_INS_RD,
      S_INS_WR,
      S_REM_RD,
      S_REM_WR,
      S_READ_RD,
      S_READ_OUT
   } state_type;

endpackage

@@ sv/sist_ram.sv @@
// ----------------------------------------------------------------------------
// sist_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module sist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/sorted_integer_set_table_top.sv @@
// ----------------------------------------------------------------------------
// sorted_integer_set_table_top
// ascending set of distinct signed 32-bit values with insert, remove and read
// ----------------------------------------------------------------------------
// sequence: insert and remove first search up from position 0; an insert then
//   shifts larger entries up and writes the value, a remove shifts later entries down
// throughput: one request at a time; each entry visited needs a read state and then a compare or write state (one ram
//   port, registered read data); busy falls as the result is strobed
// reset: synchronous, clears the sequencer, count and strobe; entry ram is not
//   cleared, only positions below count are ever read; the receiver cannot stall
`include "sorted_integer_set_table_top_macros.svh"

module sorted_integer_set_table_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  sist_pkg::sist_req_type req_item,
   output logic                  rsp_strobe,
   output sist_pkg::sist_rsp_type rsp_item
);

   import sist_pkg::*;

   // sequencer and datapath registers
   state_type    state_ff, state_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] target_ff, target_in;
   logic [CNT_W-1:0] count_ff, count_in;
   sist_req_type req_ff, req_in;
   sist_rsp_type rsp_ff, rsp_in;
   logic         rsp_strobe_ff, rsp_strobe_in;

   // entry ram controls
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [VALUE_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [VALUE_W-1:0] ram_rd_data;

   // shared compare unit: stored entry against the request value
   logic cmp_eq;
   logic cmp_gt;
   logic srch_end;
   logic set_full;
   logic ins_done;
   logic rem_done;
   logic pos_ok;
   logic is_insert;

   assign cmp_eq    = $signed(ram_rd_data) == $signed(req_ff.value);
   assign cmp_gt    = $signed(ram_rd_data) >  $signed(req_ff.value);
   assign srch_end  = ptr_ff == count_ff;
   assign set_full  = count_ff >= CNT_W'(CAPACITY);
   assign ins_done  = ptr_ff == target_ff;
   assign rem_done  = (ptr_ff + CNT_W'(1)) == count_ff;
   assign pos_ok    = CMP_W'(req_ff.position) < CMP_W'(count_ff);
   assign is_insert = req_ff.req_type == REQ_INSERT;

   function automatic sist_rsp_type make_rsp(
      input logic [STATUS_W-1:0]  status,
      input logic                 valid,
      input logic [VALUE_W-1:0]   entry,
      input logic [CNT_W-1:0]     cnt
   );
      sist_rsp_type r;
      r.status         = status;
      r.position_valid = valid;
      r.entry_value    = entry;
      r.entry_count    = ENTRY_COUNT_W'(cnt);
      return r;
   endfunction

   sist_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_item.req_type)
                  REQ_INSERT, REQ_REMOVE: state_in = S_SRCH_RD;
                  REQ_READ:               state_in = S_READ_RD;
                  default:                state_in = S_IDLE;
               endcase
            end
         end
         S_SRCH_RD: begin
            if (srch_end) begin
               state_in = (is_insert && !set_full) ? S_INS_RD : S_IDLE;
            end else begin
               state_in = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (cmp_eq) begin
               state_in = is_insert ? S_IDLE : S_REM_RD;
            end else if (cmp_gt) begin
               state_in = (is_insert && !set_full) ? S_INS_RD : S_IDLE;
            end else begin
               state_in = S_SRCH_RD;
            end
         end
         S_INS_RD:   state_in = ins_done ? S_IDLE : S_INS_WR;
         S_INS_WR:   state_in = S_INS_RD;
         S_REM_RD:   state_in = rem_done ? S_IDLE : S_REM_WR;
         S_REM_WR:   state_in = S_REM_RD;
         S_READ_RD:  state_in = pos_ok ? S_READ_OUT : S_IDLE;
         S_READ_OUT: state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      ptr_in        = ptr_ff;
      target_in     = target_ff;
      count_in      = count_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = ptr_ff[IDX_W-1:0];
      ram_wr_data   = ram_rd_data;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = ptr_ff[IDX_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               // request transfer
               req_in = req_item;
               ptr_in = '0;
               if (req_item.req_type != REQ_INSERT && req_item.req_type != REQ_REMOVE
                   && req_item.req_type != REQ_READ) begin
                  // unused type answers as an invalid read
                  rsp_in        = make_rsp(STATUS_READ, 1'b0, '0, count_ff);
                  rsp_strobe_in = 1'b1;
               end
            end
         end
         S_SRCH_RD: begin
            if (srch_end) begin
               // value above every entry, or set empty
               if (!is_insert) begin
                  rsp_in        = make_rsp(STATUS_NOT_FOUND, 1'b0, '0, count_ff);
                  rsp_strobe_in = 1'b1;
               end else if (set_full) begin
                  rsp_in        = make_rsp(STATUS_FULL, 1'b0, '0, count_ff);
                  rsp_strobe_in = 1'b1;
               end else begin
                  target_in = ptr_ff;
                  ptr_in    = count_ff;
               end
            end else begin
               ram_rd_en = 1'b1;
            end
         end
         S_SRCH_CMP: begin
            if (cmp_eq) begin
               if (is_insert) begin
                  rsp_in        = make_rsp(STATUS_DUPLICATE, 1'b0, '0, count_ff);
                  rsp_strobe_in = 1'b1;
               end
            end else if (cmp_gt) begin
               // first larger entry: insert slot, or proof of absence
               if (!is_insert) begin
                  rsp_in        = make_rsp(STATUS_NOT_FOUND, 1'b0, '0, count_ff);
                  rsp_strobe_in = 1'b1;
               end else if (set_full) begin
                  rsp_in        = make_rsp(STATUS_FULL, 1'b0, '0, count_ff);
                  rsp_strobe_in = 1'b1;
               end else begin
                  target_in = ptr_ff;
                  ptr_in    = count_ff;
               end
            end else begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
         end
         S_INS_RD: begin
            if (ins_done) begin
               ram_wr_en     = 1'b1;
               ram_wr_addr   = target_ff[IDX_W-1:0];
               ram_wr_data   = req_ff.value;
               count_in      = count_ff + CNT_W'(1);
               rsp_in        = make_rsp(STATUS_INSERTED, 1'b0, '0, count_in);
               rsp_strobe_in = 1'b1;
            end else begin
               // fetch the entry below the hole
               ram_rd_en   = 1'b1;
               ram_rd_addr = IDX_W'(ptr_ff - CNT_W'(1));
            end
         end
         S_INS_WR: begin
            ram_wr_en = 1'b1;
            ptr_in    = ptr_ff - CNT_W'(1);
         end
         S_REM_RD: begin
            if (rem_done) begin
               count_in      = count_ff - CNT_W'(1);
               rsp_in        = make_rsp(STATUS_REMOVED, 1'b0, '0, count_in);
               rsp_strobe_in = 1'b1;
            end else begin
               // fetch the entry above the gap
               ram_rd_en   = 1'b1;
               ram_rd_addr = IDX_W'(ptr_ff + CNT_W'(1));
            end
         end
         S_REM_WR: begin
            ram_wr_en = 1'b1;
            ptr_in    = ptr_ff + CNT_W'(1);
         end
         S_READ_RD: begin
            if (pos_ok) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = IDX_W'(req_ff.position);
            end else begin
               rsp_in        = make_rsp(STATUS_READ, 1'b0, '0, count_ff);
               rsp_strobe_in = 1'b1;
            end
         end
         S_READ_OUT: begin
            rsp_in        = make_rsp(STATUS_READ, 1'b1, ram_rd_data, count_ff);
            rsp_strobe_in = 1'b1;
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      target_ff <= target_in;
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // every result reports the live count
   `SIST_ASSERT_IMP(a_rsp_count, clock, reset, rsp_strobe_ff,
      rsp_ff.entry_count == ENTRY_COUNT_W'(count_ff))
   // an accepted request keeps the block busy next cycle unless answered at once
   `SIST_ASSERT_NXT(a_accept_busy, clock, reset,
      start && !busy && (req_item.req_type == REQ_INSERT ||
      req_item.req_type == REQ_REMOVE || req_item.req_type == REQ_READ),
      busy)
   // the result cycle finds the sequencer back at rest
   `SIST_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_strobe_ff, !busy)
   // a successful insert grows the set by one
   `SIST_ASSERT_IMP(a_ins_count, clock, reset,
      rsp_strobe_ff && rsp_ff.status == STATUS_INSERTED,
      count_ff == $past(count_ff) + CNT_W'(1))
   // entry value only carries data for a valid read
   `SIST_ASSERT_IMP(a_rsp_zero, clock, reset, rsp_strobe_ff && !rsp_ff.position_valid,
      rsp_ff.entry_value == '0)

endmodule

@@ verif/sist_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sist_result_checker
// watches the request and result channels of the sorted integer set table,
// keeps its own ordered copy of the set and compares every strobed result
// ----------------------------------------------------------------------------
module sist_result_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  sist_pkg::sist_req_type req_item,
   input  logic                   rsp_strobe,
   input  sist_pkg::sist_rsp_type rsp_item,
   output int                     fail_count,
   output int                     pending,
   output int                     results_checked,
   output int                     full_hits,
   output int                     duplicate_hits,
   output int                     missing_hits,
   output int                     invalid_reads
);

   import sist_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // ascending copy of the set, valid below set_size
   logic signed [VALUE_W-1:0] set_vals [CAPACITY];
   int                        set_size;

   sist_rsp_type rsp_expect_q[$];
   sist_rsp_type want;

   function automatic int find_value(logic signed [VALUE_W-1:0] v);
      int hit;
      hit = -1;
      for (int i = 0; i < set_size; i++) begin
         if (hit < 0 && set_vals[i] == v) hit = i;
      end
      return hit;
   endfunction

   // applies one request to the set and returns the result it should produce
   function automatic sist_rsp_type apply_request(sist_req_type r);
      sist_rsp_type o;
      int           hit;
      int           slot;
      o        = '0;
      o.status = STATUS_READ;
      case (r.req_type)
         REQ_INSERT: begin
            hit = find_value(r.value);
            if (hit >= 0) begin
               o.status = STATUS_DUPLICATE;
               duplicate_hits++;
            end else if (set_size >= CAPACITY) begin
               o.status = STATUS_FULL;
               full_hits++;
            end else begin
               slot = set_size;
               while (slot > 0 && set_vals[slot-1] > r.value) begin
                  set_vals[slot] = set_vals[slot-1];
                  slot--;
               end
               set_vals[slot] = r.value;
               set_size++;
               o.status = STATUS_INSERTED;
            end
         end
         REQ_REMOVE: begin
            hit = find_value(r.value);
            if (hit < 0) begin
               o.status = STATUS_NOT_FOUND;
               missing_hits++;
            end else begin
               for (int i = hit; i + 1 < set_size; i++) set_vals[i] = set_vals[i+1];
               set_size--;
               o.status = STATUS_REMOVED;
            end
         end
         REQ_READ: begin
            if (int'(r.position) < set_size) begin
               o.position_valid = 1'b1;
               o.entry_value    = set_vals[r.position];
            end else begin
               invalid_reads++;
            end
         end
         default: ;   // unused code, answered like an out-of-range read
      endcase
      o.entry_count = ENTRY_COUNT_W'(set_size);
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         set_size = 0;
         rsp_expect_q.delete();
         fail_count      = 0;
         results_checked = 0;
         full_hits       = 0;
         duplicate_hits  = 0;
         missing_hits    = 0;
         invalid_reads   = 0;
      end else begin
         // the oldest request is answered first, so compare before queueing
         if (rsp_strobe) begin
            if (rsp_expect_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: result with no request outstanding: status %0d count %0d",
                           $realtime, rsp_item.status, rsp_item.entry_count);
            end else begin
               want = rsp_expect_q.pop_front();
               results_checked++;
               if (rsp_item.status !== want.status ||
                   rsp_item.position_valid !== want.position_valid ||
                   rsp_item.entry_value !== want.entry_value ||
                   rsp_item.entry_count !== want.entry_count) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("%0t: mismatch, want status %0d valid %0b value %0d count %0d",
                              $realtime, want.status, want.position_valid,
                              want.entry_value, want.entry_count);
                     $display("%0t:            got status %0d valid %0b value %0d count %0d",
                              $realtime, rsp_item.status, rsp_item.position_valid,
                              rsp_item.entry_value, rsp_item.entry_count);
                  end
               end
            end
         end
         if (start && !busy) rsp_expect_q.push_back(apply_request(req_item));
      end
      pending = rsp_expect_q.size();
   end

endmodule

@@ verif/sorted_integer_set_table_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_integer_set_table_top_tb
// drives insert, remove and read requests into the set table with random
// gaps; a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module sorted_integer_set_table_top_tb;
   import sist_pkg::*;

   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
   localparam logic [1:0] REQ_UNUSED  = 2'd3;
   localparam int         POOL_SIZE   = 20;   // a little more than the capacity
   localparam int         BLOCKS      = 14;
   localparam int         BLOCK_ITEMS = 50;

   // random mix of one block
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_type;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   sist_req_type req_item;
   logic         rsp_strobe;
   sist_rsp_type rsp_item;

   int fail_count;
   int pending;
   int results_checked;
   int full_hits;
   int duplicate_hits;
   int missing_hits;
   int invalid_reads;

   // stimulus bookkeeping
   int                        sent_count;
   bit                        idle_on;
   logic signed [VALUE_W-1:0] value_pool [POOL_SIZE];

   sorted_integer_set_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   sist_result_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_item        (req_item),
      .rsp_strobe      (rsp_strobe),
      .rsp_item        (rsp_item),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked),
      .full_hits       (full_hits),
      .duplicate_hits  (duplicate_hits),
      .missing_hits    (missing_hits),
      .invalid_reads   (invalid_reads)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // one request transfer: optional gap, then hold start until busy is low at
   // a rising edge; start stays high into the next transfer when there is no gap
   task automatic send_request(input logic [1:0] kind, input logic signed [VALUE_W-1:0] v,
                               input logic [POS_W-1:0] pos);
      sist_req_type r;
      int           gap;
      r.req_type = kind;
      r.value    = v;
      r.position = pos;
      gap = (idle_on && $urandom_range(99) < 14) ? $urandom_range(1, 4) : 0;
      @(negedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
   endtask

   // hold off the sender until every outstanding result has come back
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // new value pool for a block: mostly wide random values, some small
   // values that collide often, and the range extremes
   task automatic refill_pool();
      int pick;
      for (int i = 0; i < POOL_SIZE; i++) begin
         pick = $urandom_range(9);
         case (pick)
            0: value_pool[i] = VAL_MIN;
            1: value_pool[i] = VAL_MAX;
            2, 3: value_pool[i] = $signed($urandom_range(20)) - 10;
            default: value_pool[i] = $urandom;
         endcase
      end
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value(int pool_pct);
      if ($urandom_range(99) < pool_pct) return value_pool[$urandom_range(POOL_SIZE - 1)];
      return $urandom;
   endfunction

   task automatic random_block(input mix_type mix);
      int ins_pct;
      int rem_pct;
      int roll;
      case (mix)
         MIX_FILL:  begin ins_pct = 70; rem_pct = 12; end
         MIX_DRAIN: begin ins_pct = 15; rem_pct = 65; end
         default:   begin ins_pct = 40; rem_pct = 40; end
      endcase
      refill_pool();
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
         roll = $urandom_range(99);
         if (roll < ins_pct)
            send_request(REQ_INSERT, pick_value(80), POS_W'($urandom_range(15)));
         else if (roll < ins_pct + rem_pct)
            send_request(REQ_REMOVE, pick_value(85), POS_W'($urandom_range(15)));
         else if (roll < 97)
            send_request(REQ_READ, $urandom, POS_W'($urandom_range(15)));
         else
            send_request(REQ_UNUSED, $urandom, POS_W'($urandom_range(15)));
      end
   endtask

   // stimulus
   initial begin
      int waited;
      mix_type mix;
      reset      = 1'b1;
      start      = 1'b0;
      req_item   = '0;
      sent_count = 0;
      idle_on    = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty set, extremes, duplicate, remove hit and miss
      send_request(REQ_READ, 32'sd0, 4'd15);       // read of an empty set
      send_request(REQ_UNUSED, VAL_MAX, 4'd0);     // unused request code
      send_request(REQ_REMOVE, 32'sd5, 4'd0);      // remove from an empty set
      send_request(REQ_INSERT, VAL_MAX, 4'd0);
      send_request(REQ_INSERT, VAL_MIN, 4'd0);
      send_request(REQ_INSERT, 32'sd0, 4'd0);
      send_request(REQ_INSERT, -32'sd1, 4'd0);
      send_request(REQ_INSERT, VAL_MAX, 4'd0);     // duplicate
      send_request(REQ_READ, 32'sd0, 4'd0);
      send_request(REQ_READ, 32'sd0, 4'd3);
      send_request(REQ_REMOVE, VAL_MIN, 4'd0);     // remove at the low end
      send_request(REQ_REMOVE, 32'sd1234, 4'd0);   // absent value

      // fill to capacity, then full and duplicate-while-full
      for (int i = 0; i < 13; i++) send_request(REQ_INSERT, i * 1000 + 7, 4'd0);
      send_request(REQ_INSERT, 32'sd5, 4'd0);      // set full
      send_request(REQ_INSERT, 32'sd7, 4'd0);      // duplicate checked before full
      send_request(REQ_READ, 32'sd0, 4'd15);       // last position of a full set
      drain_results();

      // random part; blocks 4 to 6 run without any gaps
      for (int b = 0; b < BLOCKS; b++) begin
         idle_on = !(b >= 4 && b <= 6);
         case (b % 3)
            0: mix = MIX_FILL;
            1: mix = MIX_BALANCED;
            default: mix = MIX_DRAIN;
         endcase
         random_block(mix);
         if (b % 4 == 3) drain_results();
      end

      @(negedge clock);
      start <= 1'b0;

      // wait for the last results, then a margin over the longest latency
      waited = 0;
      while (pending != 0 && waited < 2000) begin
         @(negedge clock);
         waited++;
      end
      repeat (40) @(negedge clock);

      $display("run covered %0d requests, %0d results checked", sent_count, results_checked);
      $display("full %0d, duplicate %0d, absent remove %0d, out-of-range read %0d",
               full_hits, duplicate_hits, missing_hits, invalid_reads);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog, well above the slowest legal run
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
